// ----- rtl/ostb_pkg.sv -----
// Shared types and codes for the one-shot timer bank.
// No dependencies; used by every module of the block.
package ostb_pkg;

    // Parameter defaults and fixed widths
    localparam int DEF_TIMER_SLOTS = 16;
    localparam int RESULT_CAP      = 16;
    localparam int CNT_W           = 5;
    localparam int DUR_W           = 24;
    localparam int ELAP_W          = 25;
    localparam int STEP_W          = 10;
    localparam int SLOT_W          = 4;
    localparam logic [STEP_W-1:0] STEP_RESET = 10'd16;

    // Input opcodes
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // Result event codes
    localparam logic [1:0] EV_ADDED   = 2'd0;
    localparam logic [1:0] EV_FULL    = 2'd1;
    localparam logic [1:0] EV_EXPIRED = 2'd2;
    localparam logic [1:0] EV_NONE    = 2'd3;

    // Contents of one timer cell
    typedef struct packed {
        logic              active;
        logic [DUR_W-1:0]  dur;
        logic [ELAP_W-1:0] elapsed;
    } t_slot;

    // Status from the head update logic to the sequencer
    typedef struct packed {
        logic expired;
        logic take;
    } t_head_flags;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_ADD,
        ST_FIN
    } t_state;

endpackage

// ----- rtl/ostb_cell.sv -----
// One timer cell of the rotating chain: active flag, duration, elapsed count.
// Depends on ostb_pkg.
module ostb_cell
    import ostb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,   // take the neighbor's contents this cycle
    input  logic  i_clr,     // drop the active flag
    input  t_slot i_in,
    output t_slot o_q
);

    logic              r_active;
    logic [DUR_W-1:0]  r_dur;
    logic [ELAP_W-1:0] r_elapsed;

    // Active flag: cleared by reset, remove or clear; a shift loads it instead
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_shift) begin
            r_active <= i_in.active;
        end else if (i_clr) begin
            r_active <= 1'b0;
        end
    end

    // Payload moves with the chain
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_dur     <= i_in.dur;
            r_elapsed <= i_in.elapsed;
        end
    end

    assign o_q = '{active: r_active, dur: r_dur, elapsed: r_elapsed};

endmodule

// ----- rtl/ostb_head.sv -----
// Update logic at the head of the cell chain: tick advance/expiry and slot take.
// Depends on ostb_pkg.
module ostb_head
    import ostb_pkg::*;
(
    input  t_slot             i_head,
    input  logic [STEP_W-1:0] i_step,
    input  logic [DUR_W-1:0]  i_dur,
    input  logic              i_is_tick,
    input  logic              i_is_add,
    input  logic              i_found,
    output t_slot             o_new,
    output t_head_flags       o_flags
);

    logic [ELAP_W-1:0] w_sum;
    logic              w_expired;
    logic              w_take;

    // Elapsed count cannot overflow 25 bits for an active slot
    assign w_sum     = i_head.elapsed + ELAP_W'(i_step);
    assign w_expired = i_is_tick && i_head.active && (w_sum >= ELAP_W'(i_head.dur));
    assign w_take    = i_is_add && !i_found && !i_head.active;

    always_comb begin
        o_new = i_head;
        if (i_is_tick && i_head.active) begin
            o_new.elapsed = w_sum;
            if (w_expired) begin
                o_new.active = 1'b0;
            end
        end
        if (w_take) begin
            o_new.active  = 1'b1;
            o_new.dur     = i_dur;
            o_new.elapsed = '0;
        end
    end

    assign o_flags = '{expired: w_expired, take: w_take};

endmodule

// ----- rtl/one_shot_timer_bank.sv -----
// Top level of the one-shot timer bank: command sequencer, output register,
// and the rotating chain of timer cells. Depends on ostb_pkg, ostb_cell, ostb_head.
//
// Usage:
//   Commands enter on the slave stream (tuser = opcode, tdata = duration and
//   slot). Results leave on the master stream (tuser = event, tdata = slot,
//   tlast marks the final result of a command). The user must write step_ms through
//   i_cfg_we / i_cfg_wdata only while the block is idle; the block does not check.
// Timing:
//   The TIMER_SLOTS cells form a ring that, during tick and add, rotates one
//   position per cycle unless an output stall halts it; the head cell is
//   updated as it passes. Tick and add take one full turn of the ring, then
//   post the final result; remove and clear act at accept. One command is
//   in work at a time. Each tick result is held one step so tlast can be set
//   on the final one.
// Reset:
//   All timers inactive, step_ms = 16, output empty.
// Stalls:
//   A single output register sits between the sides. While it is full and the
//   receiver holds tready low, the ring halts when another expiry must be
//   posted, and the closing beat waits; tready on the slave side stays low
//   until the command has posted its closing beat.
module one_shot_timer_bank
    import ostb_pkg::*;
#(
    parameter int TIMER_SLOTS = DEF_TIMER_SLOTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_we,
    input  logic [STEP_W-1:0] i_cfg_wdata,    // step_ms
    // command stream
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [31:0]       i_s_tdata,      // [23:0] duration_ms, [27:24] slot
    input  logic [1:0]        i_s_tuser,      // [1:0] opcode
    // result stream
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [7:0]        o_m_tdata,      // [3:0] slot_out
    output logic [1:0]        o_m_tuser,      // [1:0] event_res
    output logic              o_m_tlast       // last
);

    localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int SW = (IW > SLOT_W) ? IW : SLOT_W;

    // Registers
    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step;
    logic [DUR_W-1:0]    r_dur, n_dur;
    logic [1:0]          r_op, n_op;
    logic [IW-1:0]       r_idx, n_idx;
    logic                r_hit, n_hit;
    logic [SLOT_W-1:0]   r_hit_slot, n_hit_slot;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_out_valid, n_out_valid;
    logic [1:0]          r_out_evt, n_out_evt;
    logic [SLOT_W-1:0]   r_out_slot, n_out_slot;
    logic                r_out_last, n_out_last;

    // Chain signals
    t_slot               w_q [TIMER_SLOTS];
    t_slot               w_head_new;
    t_head_flags         w_flags;
    logic                w_shift;
    logic                w_clr_all;
    logic                w_rm;
    logic [SLOT_W-1:0]   w_rm_slot;

    logic                w_accept;
    logic                w_can_load;
    logic                w_report;
    logic                w_last_idx;
    logic [SW-1:0]       w_idx_ext;
    logic [SLOT_W-1:0]   w_idx_slot;

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_can_load = !r_out_valid || i_m_tready;
    assign w_last_idx = (r_idx == IW'(TIMER_SLOTS - 1));
    assign w_idx_ext  = SW'(r_idx);
    assign w_idx_slot = w_idx_ext[SLOT_W-1:0];
    assign w_rm_slot  = i_s_tdata[27:24];
    assign w_clr_all  = w_accept && (i_s_tuser == OP_CLEAR);
    assign w_rm       = w_accept && (i_s_tuser == OP_REMOVE);
    assign w_report   = w_flags.expired && (r_cnt < CNT_W'(RESULT_CAP));

    // Head update
    ostb_head u_head (
        .i_head    (w_q[0]),
        .i_step    (r_step),
        .i_dur     (r_dur),
        .i_is_tick (r_state == ST_TICK),
        .i_is_add  (r_state == ST_ADD),
        .i_found   (r_hit),
        .o_new     (w_head_new),
        .o_flags   (w_flags)
    );

    // Ring of cells; the updated head re-enters at the tail
    for (genvar k = 0; k < TIMER_SLOTS; k++) begin : g_cell
        t_slot w_in;
        logic  w_clr;
        if (k == TIMER_SLOTS - 1) begin : g_tail
            assign w_in = w_head_new;
        end else begin : g_mid
            assign w_in = w_q[k+1];
        end
        assign w_clr = w_clr_all || (w_rm && (32'(w_rm_slot) == 32'(k)));
        ostb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_clr   (w_clr),
            .i_in    (w_in),
            .o_q     (w_q[k])
        );
    end

    // Sequencer: next state and outputs
    always_comb begin
        n_state     = r_state;
        n_dur       = r_dur;
        n_op        = r_op;
        n_idx       = r_idx;
        n_hit       = r_hit;
        n_hit_slot  = r_hit_slot;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_evt   = r_out_evt;
        n_out_slot  = r_out_slot;
        n_out_last  = r_out_last;
        w_shift     = 1'b0;
        o_s_tready  = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_op       = i_s_tuser;
                    n_dur      = i_s_tdata[DUR_W-1:0];
                    n_idx      = '0;
                    n_hit      = 1'b0;
                    n_hit_slot = '0;
                    n_cnt      = '0;
                    unique case (i_s_tuser)
                        OP_TICK: n_state = ST_TICK;
                        OP_ADD:  n_state = ST_ADD;
                        default: n_state = ST_FIN;
                    endcase
                end
            end
            ST_TICK: begin
                // hold a new expiry until the pending one can be posted
                if (!(w_report && r_hit && !w_can_load)) begin
                    w_shift = 1'b1;
                    if (w_report) begin
                        if (r_hit) begin
                            n_out_valid = 1'b1;
                            n_out_evt   = EV_EXPIRED;
                            n_out_slot  = r_hit_slot;
                            n_out_last  = 1'b0;
                        end
                        n_hit      = 1'b1;
                        n_hit_slot = w_idx_slot;
                        n_cnt      = r_cnt + CNT_W'(1);
                    end
                    if (w_last_idx) begin
                        n_state = ST_FIN;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            ST_ADD: begin
                w_shift = 1'b1;
                if (w_flags.take) begin
                    n_hit      = 1'b1;
                    n_hit_slot = w_idx_slot;
                end
                if (w_last_idx) begin
                    n_state = ST_FIN;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            ST_FIN: begin
                // post the final beat of the command
                if (w_can_load) begin
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b1;
                    n_out_slot  = '0;
                    n_out_evt   = EV_NONE;
                    if (r_op == OP_TICK && r_hit) begin
                        n_out_evt  = EV_EXPIRED;
                        n_out_slot = r_hit_slot;
                    end else if (r_op == OP_ADD) begin
                        n_out_evt  = r_hit ? EV_ADDED : EV_FULL;
                        n_out_slot = r_hit ? r_hit_slot : '0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_RESET;
            r_op        <= OP_TICK;
            r_idx       <= '0;
            r_hit       <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_step <= i_cfg_wdata;
            end
            r_op        <= n_op;
            r_idx       <= n_idx;
            r_hit       <= n_hit;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_dur      <= n_dur;
        r_hit_slot <= n_hit_slot;
        r_out_evt  <= n_out_evt;
        r_out_slot <= n_out_slot;
        r_out_last <= n_out_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out_slot};
    assign o_m_tuser  = r_out_evt;
    assign o_m_tlast  = r_out_last;

endmodule
